FILE: hdl/rlt_pkg.sv
// Shared types and constants for the recursive lock table.
`default_nettype none

package rlt_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_UNINIT   = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    // Fixed field widths of the stream payload
    localparam int OP_W        = 2;
    localparam int LOCK_IDX_W  = 6;
    localparam int OWNER_ID_W  = 16;
    localparam int CPU_IDX_W   = 3;
    localparam int DEPTH_OUT_W = 16;
    localparam int CNT_W       = 7;
    localparam int CPU_ENTRY_W = CNT_W + 1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Input tdata bit positions
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_OWNER_LSB = IN_IDX_LSB + LOCK_IDX_W;
    localparam int IN_CPU_LSB   = IN_OWNER_LSB + OWNER_ID_W;
    localparam int IN_GTYPE_BIT = IN_CPU_LSB + CPU_IDX_W;
    localparam int IN_IRQ_BIT   = IN_GTYPE_BIT + 1;

    // Output tdata bit positions
    localparam int OUT_GRANT_BIT   = 0;
    localparam int OUT_RESTORE_BIT = 1;
    localparam int OUT_ERR_LSB     = 2;
    localparam int OUT_DEPTH_LSB   = OUT_ERR_LSB + 2;
    localparam int OUT_CNT_LSB     = OUT_DEPTH_LSB + DEPTH_OUT_W;
    localparam int OUT_USED_W      = OUT_CNT_LSB + CNT_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

`default_nettype wire

FILE: hdl/rlt_table.sv
// Synchronous state memory with per-entry valid bits and same-edge write forwarding.
`default_nettype none

module rlt_table #(
    parameter int DEPTH = 64,
    parameter int DW    = 34,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_vld;
    logic             r_byp_hit;
    logic [DW-1:0]    r_byp_data;

    // Entry valid bits: a never-written entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Memory array write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // Registered read port, control; a write at the read edge overrides the array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld  <= r_vld[i_rd_addr];
            r_byp_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp_hit ? r_byp_data : (r_rd_vld ? r_rd_data : '0);

endmodule

`default_nettype wire

FILE: hdl/recursive_lock_table_unit.sv
// Recursive lock table: top level with request pipeline and read-modify-write logic.
//
// One request per cycle is sustained while the result side does not stall. A
// request is held in the stage 1 registers after acceptance, and its result is
// loaded into the output register when stage 1 advances. The lock table and the
// per-processor table each sit in a registered-read memory: the request reads
// both tables on acceptance, and stage 1 then computes the update, writes it
// back and loads the output register. A write landing on the same
// entry as the next request's read is forwarded, so back-to-back requests to one
// lock see each other's effect. Valid bits in flip-flops stand for the zero reset
// of every entry, so the block is ready right after reset with no clearing pass.
// The result register decouples the sides: a new request is taken while a result
// waits.
`default_nettype none

module recursive_lock_table_unit #(
    parameter int NUM_LOCKS  = 64,
    parameter int NUM_CPUS   = 8,
    parameter int OWNER_BITS = 16,
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration: system_ready
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic                            i_cfg_data,
    // request stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: lock_index[5:0], owner_id[21:6], processor_id[24:22],
    //        global_type[25], interrupts_were_enabled[26], zero[31:27]
    input  wire logic [rlt_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: op[1:0]
    input  wire logic [rlt_pkg::OP_W-1:0]       i_s_tuser,
    // result stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // tdata: granted[0], restore_interrupts[1], error_code[3:2],
    //        depth_after[19:4], global_count_after[26:20], zero[31:27]
    output logic      [rlt_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    localparam int LOCK_AW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int CPU_AW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CPU_IW  = (CPU_AW > rlt_pkg::CPU_IDX_W) ? CPU_AW : rlt_pkg::CPU_IDX_W;
    localparam int LOCK_DW = 2 + DEPTH_BITS + OWNER_BITS;
    localparam int DEP_LSB = OWNER_BITS;
    localparam int GLB_BIT = OWNER_BITS + DEPTH_BITS;
    localparam int INI_BIT = GLB_BIT + 1;

    // Input field decode
    logic [rlt_pkg::LOCK_IDX_W-1:0] in_idx;
    logic [CPU_IW-1:0]              in_cpu;
    logic                           in_lock_ok;
    logic                           in_cpu_ok;
    logic                           s_acc;
    logic                           s1_adv;

    // Stage 1 registers
    logic                    r_s1_v;
    logic [rlt_pkg::OP_W-1:0] r_op;
    logic                    r_lock_ok;
    logic                    r_cpu_ok;
    logic [LOCK_AW-1:0]      r_lock_addr;
    logic [CPU_AW-1:0]       r_cpu_addr;
    logic [OWNER_BITS-1:0]   r_who;
    logic                    r_gtype;
    logic                    r_irq;
    logic                    r_sys_ready;

    // Output register
    logic                           r_out_v;
    logic [rlt_pkg::OUT_DATA_W-1:0] r_out_data;

    // Table read data and update
    logic [LOCK_DW-1:0]              lock_rd;
    logic [rlt_pkg::CPU_ENTRY_W-1:0] cpu_rd;
    logic [LOCK_DW-1:0]              n_lock;
    logic [rlt_pkg::CPU_ENTRY_W-1:0] n_cpu;
    logic                            lock_we;
    logic                            cpu_we;

    logic                       l_init;
    logic                       l_glb;
    logic [DEPTH_BITS-1:0]      l_dep;
    logic [OWNER_BITS-1:0]      l_hld;
    logic [rlt_pkg::CNT_W-1:0]  c_cnt;
    logic                       c_sav;
    logic [DEPTH_BITS-1:0]      n_dep;
    logic [OWNER_BITS-1:0]      n_hld;
    logic                       n_init;
    logic                       n_glb;
    logic [rlt_pkg::CNT_W-1:0]  n_cnt;
    logic                       n_sav;
    logic                       res_grant;
    logic                       res_restore;
    rlt_pkg::t_err              res_err;
    logic [rlt_pkg::OUT_DATA_W-1:0] n_out_data;

    assign in_idx     = i_s_tdata[rlt_pkg::IN_IDX_LSB +: rlt_pkg::LOCK_IDX_W];
    assign in_cpu     = CPU_IW'(i_s_tdata[rlt_pkg::IN_CPU_LSB +: rlt_pkg::CPU_IDX_W]);
    assign in_lock_ok = {1'b0, in_idx} < (rlt_pkg::LOCK_IDX_W + 1)'(NUM_LOCKS);
    assign in_cpu_ok  = {1'b0, in_cpu} < (CPU_IW + 1)'(NUM_CPUS);

    // Handshake: stage 1 moves on when the output register is free or drains
    assign s1_adv      = r_s1_v && (!r_out_v || i_m_tready);
    assign o_s_tready  = !r_s1_v || s1_adv;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_v;
    assign o_m_tdata   = r_out_data;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_ready <= 1'b0;
        end else if (i_cfg_valid) begin
            r_sys_ready <= i_cfg_data;
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op        <= i_s_tuser;
            r_lock_ok   <= in_lock_ok;
            r_cpu_ok    <= in_cpu_ok;
            r_lock_addr <= in_lock_ok ? in_idx[LOCK_AW-1:0] : '0;
            r_cpu_addr  <= in_cpu_ok ? in_cpu[CPU_AW-1:0] : '0;
            r_who       <= OWNER_BITS'(i_s_tdata[rlt_pkg::IN_OWNER_LSB +: rlt_pkg::OWNER_ID_W]);
            r_gtype     <= i_s_tdata[rlt_pkg::IN_GTYPE_BIT];
            r_irq       <= i_s_tdata[rlt_pkg::IN_IRQ_BIT];
        end
    end

    // Lock table: {initialized, global, depth, holder}
    rlt_table #(
        .DEPTH (NUM_LOCKS),
        .DW    (LOCK_DW),
        .AW    (LOCK_AW)
    ) u_lock_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_acc),
        .i_rd_addr (in_lock_ok ? in_idx[LOCK_AW-1:0] : LOCK_AW'(0)),
        .i_wr_en   (lock_we && s1_adv),
        .i_wr_addr (r_lock_addr),
        .i_wr_data (n_lock),
        .o_rd_data (lock_rd)
    );

    // Processor table: {saved interrupt flag, global hold count}
    rlt_table #(
        .DEPTH (NUM_CPUS),
        .DW    (rlt_pkg::CPU_ENTRY_W),
        .AW    (CPU_AW)
    ) u_cpu_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_acc),
        .i_rd_addr (in_cpu_ok ? in_cpu[CPU_AW-1:0] : CPU_AW'(0)),
        .i_wr_en   (cpu_we && s1_adv),
        .i_wr_addr (r_cpu_addr),
        .i_wr_data (n_cpu),
        .o_rd_data (cpu_rd)
    );

    assign l_init = lock_rd[INI_BIT];
    assign l_glb  = lock_rd[GLB_BIT];
    assign l_dep  = lock_rd[DEP_LSB +: DEPTH_BITS];
    assign l_hld  = lock_rd[OWNER_BITS-1:0];
    assign c_cnt  = cpu_rd[rlt_pkg::CNT_W-1:0];
    assign c_sav  = cpu_rd[rlt_pkg::CNT_W];

    // Read-modify-write of the selected lock and processor entries
    always_comb begin
        n_init      = l_init;
        n_glb       = l_glb;
        n_dep       = l_dep;
        n_hld       = l_hld;
        n_cnt       = c_cnt;
        n_sav       = c_sav;
        lock_we     = 1'b0;
        cpu_we      = 1'b0;
        res_grant   = 1'b0;
        res_restore = 1'b0;
        res_err     = rlt_pkg::ERR_NONE;
        case (r_op)
            rlt_pkg::OP_INIT: begin
                if (r_lock_ok) begin
                    lock_we = 1'b1;
                    n_init  = 1'b1;
                    n_glb   = r_gtype;
                    n_dep   = '0;
                    n_hld   = '0;
                end
            end
            rlt_pkg::OP_ACQUIRE: begin
                if (!r_lock_ok || !l_init) begin
                    res_err = rlt_pkg::ERR_UNINIT;
                end else if ((l_dep == '0) || (l_hld == r_who)) begin
                    if (&l_dep) begin
                        res_err = rlt_pkg::ERR_OVERFLOW;
                    end else begin
                        lock_we   = 1'b1;
                        res_grant = 1'b1;
                        n_dep     = l_dep + 1'b1;
                        n_hld     = r_who;
                        // first hold of a global lock counts against the processor
                        if ((l_dep == '0) && l_glb && r_sys_ready && r_cpu_ok) begin
                            cpu_we = 1'b1;
                            if (c_cnt == '0) begin
                                n_sav = r_irq;
                            end
                            if (c_cnt != rlt_pkg::CNT_MAX) begin
                                n_cnt = c_cnt + 1'b1;
                            end
                        end
                    end
                end
            end
            rlt_pkg::OP_RELEASE: begin
                if (!r_lock_ok || !l_init) begin
                    res_err = rlt_pkg::ERR_UNINIT;
                end else if (l_dep != '0) begin
                    lock_we = 1'b1;
                    n_dep   = l_dep - 1'b1;
                    // last release frees the lock and may give back interrupts
                    if (l_dep == DEPTH_BITS'(1)) begin
                        n_hld = '0;
                        if (l_glb && r_sys_ready && r_cpu_ok) begin
                            cpu_we = 1'b1;
                            if (c_cnt != '0) begin
                                n_cnt = c_cnt - 1'b1;
                            end
                            if (n_cnt == '0) begin
                                res_restore = c_sav;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign n_lock = {n_init, n_glb, n_dep, n_hld};
    assign n_cpu  = {n_sav, n_cnt};

    // Result packing
    always_comb begin
        n_out_data = '0;
        n_out_data[rlt_pkg::OUT_GRANT_BIT]   = res_grant;
        n_out_data[rlt_pkg::OUT_RESTORE_BIT] = res_restore;
        n_out_data[rlt_pkg::OUT_ERR_LSB +: 2] = res_err;
        n_out_data[rlt_pkg::OUT_DEPTH_LSB +: rlt_pkg::DEPTH_OUT_W] =
            r_lock_ok ? rlt_pkg::DEPTH_OUT_W'(n_dep) : '0;
        n_out_data[rlt_pkg::OUT_CNT_LSB +: rlt_pkg::CNT_W] = r_cpu_ok ? n_cnt : '0;
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rlt_checker.sv
// Port-level checker for the recursive lock table, bound to the top level.
`default_nettype none

module rlt_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [rlt_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    // A stalled result stays valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result transaction dropped while stalled");

    // A stalled result keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result payload changed while stalled");

    // A grant never carries an error
    a_grant_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[rlt_pkg::OUT_GRANT_BIT] |->
            (o_m_tdata[rlt_pkg::OUT_ERR_LSB +: 2] == rlt_pkg::ERR_NONE))
        else $error("granted with error code");

    // Restore only comes from a release, never with a grant
    a_restore_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            !(o_m_tdata[rlt_pkg::OUT_GRANT_BIT] && o_m_tdata[rlt_pkg::OUT_RESTORE_BIT]))
        else $error("restore reported on a grant");

    // An uninitialized lock always reports zero depth
    a_uninit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[rlt_pkg::OUT_ERR_LSB +: 2] == rlt_pkg::ERR_UNINIT) |->
            (o_m_tdata[rlt_pkg::OUT_DEPTH_LSB +: rlt_pkg::DEPTH_OUT_W] == '0))
        else $error("uninitialized lock with nonzero depth");

endmodule

bind recursive_lock_table_unit rlt_checker u_rlt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

FILE: tb/lock_table_checker.sv
// Checker for the lock table: tracks every channel, predicts each reply and compares it.
`default_nettype none

module lock_table_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic        i_cfg_data,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [31:0] i_req_data,
    input  wire logic [1:0]  i_req_user,
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_ready,
    input  wire logic [31:0] i_rsp_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOCKS = 64;
    localparam int CPUS  = 8;
    localparam logic [rlt_pkg::DEPTH_OUT_W-1:0] DEPTH_LIMIT = '1;

    typedef struct packed {
        logic                            granted;
        logic                            restore;
        rlt_pkg::t_err                   err;
        logic [rlt_pkg::DEPTH_OUT_W-1:0] depth;
        logic [rlt_pkg::CNT_W-1:0]       count;
    } t_lock_reply;

    // Shadow copy of the lock table and the per-processor table
    logic                            lock_valid   [LOCKS];
    logic                            lock_global  [LOCKS];
    logic [rlt_pkg::DEPTH_OUT_W-1:0] lock_depth   [LOCKS];
    logic [rlt_pkg::OWNER_ID_W-1:0]  lock_holder  [LOCKS];
    logic [rlt_pkg::CNT_W-1:0]       cpu_hold_cnt [CPUS];
    logic                            cpu_saved_irq[CPUS];
    logic                            ready_mode;

    t_lock_reply expected_replies[$];
    int          fails;

    // Apply one request to the shadow tables, return the reply it should produce
    function automatic t_lock_reply predict_reply(input logic [1:0] op,
                                                  input logic [31:0] data);
        logic [rlt_pkg::LOCK_IDX_W-1:0] idx;
        logic [rlt_pkg::OWNER_ID_W-1:0] who;
        logic [rlt_pkg::CPU_IDX_W-1:0]  cpu;
        logic                           gtype;
        logic                           irq;
        t_lock_reply                    r;
        idx   = data[rlt_pkg::IN_IDX_LSB +: rlt_pkg::LOCK_IDX_W];
        who   = data[rlt_pkg::IN_OWNER_LSB +: rlt_pkg::OWNER_ID_W];
        cpu   = data[rlt_pkg::IN_CPU_LSB +: rlt_pkg::CPU_IDX_W];
        gtype = data[rlt_pkg::IN_GTYPE_BIT];
        irq   = data[rlt_pkg::IN_IRQ_BIT];
        r     = '0;
        r.err = rlt_pkg::ERR_NONE;
        case (op)
            rlt_pkg::OP_INIT: begin
                lock_valid[idx]  = 1'b1;
                lock_global[idx] = gtype;
                lock_depth[idx]  = '0;
                lock_holder[idx] = '0;
            end
            rlt_pkg::OP_ACQUIRE: begin
                if (!lock_valid[idx]) begin
                    r.err = rlt_pkg::ERR_UNINIT;
                end else if (lock_depth[idx] == 0 || lock_holder[idx] == who) begin
                    if (lock_depth[idx] == DEPTH_LIMIT) begin
                        r.err = rlt_pkg::ERR_OVERFLOW;
                    end else begin
                        // first hold of a global lock counts against the processor
                        if (lock_depth[idx] == 0 && lock_global[idx] && ready_mode) begin
                            if (cpu_hold_cnt[cpu] == 0)
                                cpu_saved_irq[cpu] = irq;
                            if (cpu_hold_cnt[cpu] != rlt_pkg::CNT_MAX)
                                cpu_hold_cnt[cpu] = cpu_hold_cnt[cpu] + 1'b1;
                        end
                        lock_depth[idx]  = lock_depth[idx] + 1'b1;
                        lock_holder[idx] = who;
                        r.granted        = 1'b1;
                    end
                end
            end
            rlt_pkg::OP_RELEASE: begin
                if (!lock_valid[idx]) begin
                    r.err = rlt_pkg::ERR_UNINIT;
                end else if (lock_depth[idx] != 0) begin
                    lock_depth[idx] = lock_depth[idx] - 1'b1;
                    if (lock_depth[idx] == 0) begin
                        // last release: give back the saved flag once the count is empty
                        if (lock_global[idx] && ready_mode) begin
                            if (cpu_hold_cnt[cpu] != 0)
                                cpu_hold_cnt[cpu] = cpu_hold_cnt[cpu] - 1'b1;
                            if (cpu_hold_cnt[cpu] == 0)
                                r.restore = cpu_saved_irq[cpu];
                        end
                        lock_holder[idx] = '0;
                    end
                end
            end
            default: ;
        endcase
        r.depth = lock_depth[idx];
        r.count = cpu_hold_cnt[cpu];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lock_reply want;
        t_lock_reply got;
        if (!i_rst_n) begin
            for (int i = 0; i < LOCKS; i++) begin
                lock_valid[i]  = 1'b0;
                lock_global[i] = 1'b0;
                lock_depth[i]  = '0;
                lock_holder[i] = '0;
            end
            for (int i = 0; i < CPUS; i++) begin
                cpu_hold_cnt[i]  = '0;
                cpu_saved_irq[i] = 1'b0;
            end
            ready_mode = 1'b0;
            fails      = 0;
            expected_replies.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            // configuration transaction
            if (i_cfg_valid && i_cfg_ready)
                ready_mode = i_cfg_data;

            // reply transaction: compare against the oldest prediction
            if (i_rsp_valid && i_rsp_ready) begin
                got.granted = i_rsp_data[rlt_pkg::OUT_GRANT_BIT];
                got.restore = i_rsp_data[rlt_pkg::OUT_RESTORE_BIT];
                got.err     = rlt_pkg::t_err'(i_rsp_data[rlt_pkg::OUT_ERR_LSB +: 2]);
                got.depth   = i_rsp_data[rlt_pkg::OUT_DEPTH_LSB +: rlt_pkg::DEPTH_OUT_W];
                got.count   = i_rsp_data[rlt_pkg::OUT_CNT_LSB +: rlt_pkg::CNT_W];
                if (expected_replies.size() == 0) begin
                    $error("reply with no request outstanding: tdata %h", i_rsp_data);
                    fails++;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.granted !== want.granted) begin
                        $error("granted: expected %0d, actual %0d", want.granted, got.granted);
                        fails++;
                    end
                    if (got.restore !== want.restore) begin
                        $error("restore_interrupts: expected %0d, actual %0d",
                               want.restore, got.restore);
                        fails++;
                    end
                    if (got.err !== want.err) begin
                        $error("error_code: expected %0d, actual %0d", want.err, got.err);
                        fails++;
                    end
                    if (got.depth !== want.depth) begin
                        $error("depth_after: expected %0d, actual %0d", want.depth, got.depth);
                        fails++;
                    end
                    if (got.count !== want.count) begin
                        $error("global_count_after: expected %0d, actual %0d",
                               want.count, got.count);
                        fails++;
                    end
                end
            end

            // request transaction
            if (i_req_valid && i_req_ready)
                expected_replies.push_back(predict_reply(i_req_user, i_req_data));

            o_pending    <= expected_replies.size();
            o_fail_count <= fails;
        end
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Top of the lock table testbench: clock, reset, request stimulus, reply stalls and verdict.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [rlt_pkg::LOCK_IDX_W-1:0] t_lock_idx;
    typedef logic [rlt_pkg::CPU_IDX_W-1:0]  t_cpu_idx;

    localparam logic [1:0]                     OP_SPARE  = 2'd3;      // opcode with no meaning
    localparam logic [rlt_pkg::OWNER_ID_W-1:0] OWNER_TAG = 16'hFEED;
    localparam int                             WATCHDOG  = 500_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data  = 1'b0;
    wire         cfg_ready;
    logic        req_valid = 1'b0;
    logic [31:0] req_data  = '0;
    logic [1:0]  req_user  = '0;
    wire         req_ready;
    wire         rsp_valid;
    logic        rsp_ready = 1'b0;
    wire  [31:0] rsp_data;
    int          fail_count;
    int          pending;

    int          burst_left = 0;
    int          sent_items = 0;
    int          cycle_count = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age   = 0;
    logic [rlt_pkg::OWNER_ID_W-1:0] owner_pool[4];

    always #4ns clk = ~clk;

    recursive_lock_table_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (req_valid),
        .o_s_tready (req_ready),
        .i_s_tdata  (req_data),
        .i_s_tuser  (req_user),
        .o_m_tvalid (rsp_valid),
        .i_m_tready (rsp_ready),
        .o_m_tdata  (rsp_data)
    );

    lock_table_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_req_data  (req_data),
        .i_req_user  (req_user),
        .i_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .i_rsp_data  (rsp_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Reply side: rotate a stall pattern, swap it for a fresh one now and then
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready     <= 1'b0;
            stall_pattern <= 16'hFFFF;
            pattern_age   <= 0;
        end else begin
            if (pattern_age == 0) begin
                stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                             : (16'($urandom) | 16'h0001);
                pattern_age   <= $urandom_range(50, 400);
            end else begin
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
                pattern_age   <= pattern_age - 1;
            end
            rsp_ready <= stall_pattern[0];
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One request transaction; bursts with random gaps between them
    task automatic send_request(input logic [1:0] op,
                                input logic [rlt_pkg::LOCK_IDX_W-1:0] idx,
                                input logic [rlt_pkg::OWNER_ID_W-1:0] who,
                                input logic [rlt_pkg::CPU_IDX_W-1:0] cpu,
                                input logic gtype, input logic irq);
        logic [31:0] word;
        int          gap;
        word = '0;
        word[rlt_pkg::IN_IDX_LSB +: rlt_pkg::LOCK_IDX_W]   = idx;
        word[rlt_pkg::IN_OWNER_LSB +: rlt_pkg::OWNER_ID_W] = who;
        word[rlt_pkg::IN_CPU_LSB +: rlt_pkg::CPU_IDX_W]    = cpu;
        word[rlt_pkg::IN_GTYPE_BIT]                        = gtype;
        word[rlt_pkg::IN_IRQ_BIT]                          = irq;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        req_valid <= 1'b1;
        req_data  <= word;
        req_user  <= op;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        sent_items++;
    endtask

    // Stop sending and wait until every reply has come back
    task automatic wait_all_replies();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ready_flag(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Nested hold: n acquires then n releases of one lock by one owner
    task automatic nested_hold();
        logic [rlt_pkg::LOCK_IDX_W-1:0] idx;
        logic [rlt_pkg::OWNER_ID_W-1:0] who;
        logic [rlt_pkg::CPU_IDX_W-1:0]  cpu;
        int                             n;
        idx = t_lock_idx'($urandom_range(0, 15));
        who = owner_pool[$urandom_range(0, 3)];
        cpu = t_cpu_idx'($urandom_range(0, 7));
        n   = $urandom_range(1, 4);
        repeat (n) send_request(rlt_pkg::OP_ACQUIRE, idx, who, cpu,
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat (n) send_request(rlt_pkg::OP_RELEASE, idx, who, cpu,
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Single request of any kind, biased toward a few contended locks
    task automatic loose_request();
        logic [1:0]                     op;
        logic [rlt_pkg::LOCK_IDX_W-1:0] idx;
        logic [rlt_pkg::OWNER_ID_W-1:0] who;
        int                             pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            op = rlt_pkg::OP_INIT;
        else if (pick < 55)
            op = rlt_pkg::OP_ACQUIRE;
        else if (pick < 96)
            op = rlt_pkg::OP_RELEASE;
        else
            op = OP_SPARE;
        idx = ($urandom_range(0, 3) != 0) ? t_lock_idx'($urandom_range(0, 7))
                                          : t_lock_idx'($urandom_range(0, 63));
        who = ($urandom_range(0, 4) != 0) ? owner_pool[$urandom_range(0, 3)] : 16'($urandom);
        send_request(op, idx, who, t_cpu_idx'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        logic phase_ready[4];
        int   goal;
        phase_ready = '{1'b0, 1'b1, 1'b0, 1'b1};
        owner_pool  = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // system not ready: untouched locks, then a global hold that is not counted
        send_request(OP_SPARE,            6'd5, 16'h0000, 3'd0, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_ACQUIRE, 6'd5, 16'h0000, 3'd0, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_RELEASE, 6'd5, 16'h0000, 3'd0, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_INIT,    6'd1, 16'h0000, 3'd3, 1'b1, 1'b0);
        send_request(rlt_pkg::OP_ACQUIRE, 6'd1, 16'h0000, 3'd3, 1'b0, 1'b1);
        wait_all_replies();
        write_ready_flag(1'b1);

        // last global release with the count already at zero
        send_request(rlt_pkg::OP_RELEASE, 6'd1, 16'h0000, 3'd3, 1'b0, 1'b0);
        // recursion on a global lock, foreign owner refused, release past zero
        send_request(rlt_pkg::OP_INIT,    6'd0,  16'h0000, 3'd0, 1'b1, 1'b0);
        send_request(rlt_pkg::OP_ACQUIRE, 6'd0,  16'hFFFF, 3'd0, 1'b0, 1'b1);
        send_request(rlt_pkg::OP_ACQUIRE, 6'd0,  16'hFFFF, 3'd0, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_ACQUIRE, 6'd0,  16'h0000, 3'd0, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_RELEASE, 6'd0,  16'h0000, 3'd0, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_RELEASE, 6'd0,  16'hFFFF, 3'd0, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_RELEASE, 6'd0,  16'hFFFF, 3'd0, 1'b0, 1'b0);
        // task lock at the top index, re-initialized while held
        send_request(rlt_pkg::OP_INIT,    6'd63, 16'h0000, 3'd4, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_ACQUIRE, 6'd63, 16'h0000, 3'd4, 1'b0, 1'b1);
        send_request(rlt_pkg::OP_ACQUIRE, 6'd63, 16'hFFFF, 3'd4, 1'b0, 1'b1);
        send_request(rlt_pkg::OP_INIT,    6'd63, 16'h0000, 3'd4, 1'b1, 1'b0);
        send_request(OP_SPARE,            6'd63, 16'hFFFF, 3'd4, 1'b1, 1'b1);
        // two global locks on one processor, released in order
        send_request(rlt_pkg::OP_ACQUIRE, 6'd63, OWNER_TAG, 3'd6, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_ACQUIRE, 6'd0,  OWNER_TAG, 3'd6, 1'b0, 1'b1);
        send_request(rlt_pkg::OP_RELEASE, 6'd63, OWNER_TAG, 3'd6, 1'b0, 1'b0);
        send_request(rlt_pkg::OP_RELEASE, 6'd0,  OWNER_TAG, 3'd6, 1'b0, 1'b0);
        wait_all_replies();

        // global count saturation: re-init of a held global lock keeps the count
        send_request(rlt_pkg::OP_INIT, 6'd9, 16'h0000, 3'd7, 1'b1, 1'b0);
        repeat (130) begin
            send_request(rlt_pkg::OP_ACQUIRE, 6'd9, 16'($urandom), 3'd7, 1'b0,
                         1'($urandom_range(0, 1)));
            send_request(rlt_pkg::OP_INIT,    6'd9, 16'h0000,      3'd7, 1'b1, 1'b0);
        end
        send_request(rlt_pkg::OP_ACQUIRE, 6'd9, OWNER_TAG, 3'd7, 1'b0, 1'b1);
        send_request(rlt_pkg::OP_RELEASE, 6'd9, OWNER_TAG, 3'd7, 1'b0, 1'b0);
        wait_all_replies();

        // random phases, the ready flag alternating between its two values
        foreach (phase_ready[p]) begin
            write_ready_flag(phase_ready[p]);
            owner_pool[2] = 16'($urandom);
            owner_pool[3] = 16'($urandom);
            goal = sent_items + 390;
            while (sent_items < goal) begin
                if ($urandom_range(0, 1) != 0)
                    nested_hold();
                else
                    loose_request();
            end
            wait_all_replies();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
